FILE: hw/rtl/imu_trp_pkg.sv
`default_nettype none

package imu_trp_pkg;

    // parser modes, the unused code behaves as find end
    typedef enum logic [1:0] {
        MODE_FIND  = 2'd0,
        MODE_LF    = 2'd1,
        MODE_PARSE = 2'd2
    } t_mode;

    localparam int DEF_MAX_FIELD_CHARS = 10;
    localparam int DEF_QUAT_FIELDS     = 4;

    // quaternion lanes carried on the output beat
    localparam int OUT_QUATS = 4;

    localparam int VAL_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int FIELD_N_W = 3;
    localparam logic [FIELD_N_W-1:0] FIELD_N_MAX = 3'd7;

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_DIG_HI = 8'h7F;

endpackage

`default_nettype wire

FILE: hw/rtl/imu_text_record_parser.sv
`default_nettype none

// text record parser for an imu serial stream. one ascii byte per input beat.
// the parser hunts for a cr lf pair, clears the record and then reads
// space separated signed decimal fields: the first QUAT_FIELDS are quaternion
// components, the next one is the timestamp, later fields are dropped. a cr
// ends the record and sends one output beat with all five values, after
// which the parser waits for lf again. only the first MAX_FIELD_CHARS
// characters of a field count; a leading '-' negates, the first byte outside
// 0x30..0x7f stops accumulation, values wrap modulo 2^32. missing quaternion
// fields read zero, a missing timestamp keeps its last value. throughput is
// one byte per clock; a byte passes an input register and its next state is
// computed combinationally (the multiply-by-ten accumulate sets that path),
// so a record beat passes the input register and then the result register.
// the input stalls only while a finished record beat waits for tready.
module imu_text_record_parser #(
    parameter int MAX_FIELD_CHARS = imu_trp_pkg::DEF_MAX_FIELD_CHARS,
    parameter int QUAT_FIELDS     = imu_trp_pkg::DEF_QUAT_FIELDS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave side: tdata = byte_in [7:0]
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,
    // master side: tdata = quat_w [31:0], quat_x [63:32], quat_y [95:64],
    // quat_z [127:96], time_stamp [159:128]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [159:0]      o_m_tdata
);

    localparam int CC_W = $clog2(MAX_FIELD_CHARS + 1);
    localparam int VW   = imu_trp_pkg::VAL_W;
    localparam int FNW  = imu_trp_pkg::FIELD_N_W;
    localparam logic [CC_W-1:0] CC_MAX = CC_W'(MAX_FIELD_CHARS);
    localparam logic [FNW-1:0]  QF_N   = FNW'(QUAT_FIELDS);

    // input register
    logic                                r_in_valid;
    logic [imu_trp_pkg::BYTE_W-1:0]      r_in_byte;

    // parser state
    imu_trp_pkg::t_mode r_mode, n_mode;
    logic [CC_W-1:0]    r_cc, n_cc;
    logic [FNW-1:0]     r_fn, n_fn;
    logic [VW-1:0]      r_acc, n_acc;
    logic               r_neg, n_neg;
    logic               r_stop, n_stop;
    logic [VW-1:0]      r_rec [QUAT_FIELDS];
    logic [VW-1:0]      n_rec [QUAT_FIELDS];
    logic [VW-1:0]      r_stamp, n_stamp;

    // result register
    logic               r_out_valid, n_out_valid;
    logic [159:0]       r_out_data, n_out_data;

    logic               advance;
    logic               proc;
    logic               emit;
    logic [VW-1:0]      commit_val;
    logic [VW-1:0]      quat [imu_trp_pkg::OUT_QUATS];
    logic [VW-1:0]      stamp_out;
    logic [VW-1:0]      acc_next;
    logic               is_digit;

    // whole path stalls only when a finished record is not taken
    assign advance    = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign commit_val = r_neg ? (VW'(0) - r_acc) : r_acc;
    assign is_digit   = (r_in_byte >= imu_trp_pkg::CHAR_ZERO)
                     && (r_in_byte <= imu_trp_pkg::CHAR_DIG_HI);
    // acc * 10 + weight
    assign acc_next   = (r_acc << 3) + (r_acc << 1)
                      + VW'(r_in_byte - imu_trp_pkg::CHAR_ZERO);

    // output lanes see the field being committed by the cr
    for (genvar k = 0; k < imu_trp_pkg::OUT_QUATS; k++) begin : g_quat
        if (k < QUAT_FIELDS) begin : g_used
            assign quat[k] = (r_fn == FNW'(k)) ? commit_val : r_rec[k];
        end else begin : g_zero
            assign quat[k] = '0;
        end
    end
    assign stamp_out = (r_fn == QF_N) ? commit_val : r_stamp;

    always_comb begin
        n_mode      = r_mode;
        n_cc        = r_cc;
        n_fn        = r_fn;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_stop      = r_stop;
        n_rec       = r_rec;
        n_stamp     = r_stamp;
        emit        = 1'b0;
        if (proc) begin
            unique case (r_mode)
                imu_trp_pkg::MODE_LF: begin
                    if (r_in_byte == imu_trp_pkg::CHAR_LF) begin
                        for (int k = 0; k < QUAT_FIELDS; k++) begin
                            n_rec[k] = '0;
                        end
                        n_fn   = '0;
                        n_cc   = '0;
                        n_acc  = '0;
                        n_neg  = 1'b0;
                        n_stop = 1'b0;
                        n_mode = imu_trp_pkg::MODE_PARSE;
                    end else begin
                        n_mode = imu_trp_pkg::MODE_FIND;
                    end
                end
                imu_trp_pkg::MODE_PARSE: begin
                    if (r_in_byte == imu_trp_pkg::CHAR_CR
                            || r_in_byte == imu_trp_pkg::CHAR_SPACE) begin
                        // commit current field
                        for (int k = 0; k < QUAT_FIELDS; k++) begin
                            if (r_fn == FNW'(k)) begin
                                n_rec[k] = commit_val;
                            end
                        end
                        if (r_fn == QF_N) begin
                            n_stamp = commit_val;
                        end
                        if (r_in_byte == imu_trp_pkg::CHAR_CR) begin
                            emit   = 1'b1;
                            n_mode = imu_trp_pkg::MODE_LF;
                        end else begin
                            n_cc   = '0;
                            n_acc  = '0;
                            n_neg  = 1'b0;
                            n_stop = 1'b0;
                            if (r_fn <= QF_N && r_fn != imu_trp_pkg::FIELD_N_MAX) begin
                                n_fn = r_fn + FNW'(1);
                            end
                        end
                    end else if (r_cc < CC_MAX) begin
                        if (r_cc == '0 && r_in_byte == imu_trp_pkg::CHAR_MINUS) begin
                            n_neg = 1'b1;
                        end else if (!r_stop && is_digit) begin
                            n_acc = acc_next;
                        end else begin
                            n_stop = 1'b1;
                        end
                        n_cc = r_cc + CC_W'(1);
                    end
                end
                default: begin
                    if (r_in_byte == imu_trp_pkg::CHAR_CR) begin
                        n_mode = imu_trp_pkg::MODE_LF;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_data  = {stamp_out, quat[3], quat[2], quat[1], quat[0]};
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= imu_trp_pkg::MODE_FIND;
            r_cc        <= '0;
            r_fn        <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_stop      <= 1'b0;
            r_stamp     <= '0;
            for (int k = 0; k < QUAT_FIELDS; k++) begin
                r_rec[k] <= '0;
            end
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_cc        <= n_cc;
            r_fn        <= n_fn;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_stop      <= n_stop;
            r_stamp     <= n_stamp;
            r_rec       <= n_rec;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire
